// ===== rtl/critical_path_activity_times_unit_macros.svh =====
// Assertion helpers shared by the RTL files.
// Both macros expect clk and rst_n to be visible where they are used.
`ifndef CRITICAL_PATH_ACTIVITY_TIMES_UNIT_MACROS_SVH
`define CRITICAL_PATH_ACTIVITY_TIMES_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// cond must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("invariant violated");
// cons must hold in the cycle after ante
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check violated");
`else
`define ASSERT_ALWAYS(lbl, cond)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/cpat_pkg.sv =====
`default_nettype none
package cpat_pkg;

  // network sizes
  localparam int MAX_ACTIVITIES = 64;
  localparam int MAX_EVENTS     = 64;
  localparam int DURATION_BITS  = 16;

  localparam int ACT_W  = 6;
  localparam int EVT_W  = 6;
  localparam int CNT_W  = $clog2(MAX_ACTIVITIES + 1);
  localparam int TIME_W = 22;

  typedef logic [TIME_W-1:0] time_t;

  // all-ones doubles as saturation limit and "latest time unset" mark
  localparam time_t TIME_MAX   = '1;
  localparam time_t TIME_UNSET = '1;

  // shared unit operations
  localparam logic ALU_ADD_SAT   = 1'b0;
  localparam logic ALU_SUB_FLOOR = 1'b1;

  typedef struct packed {
    logic  op;
    time_t a;
    time_t b;
    time_t t;
  } alu_req_t;

  typedef struct packed {
    time_t c;
    logic  better;
  } alu_rsp_t;

  typedef struct packed {
    logic [ACT_W-1:0] activity_index;
    time_t            earliest_start;
    time_t            latest_start;
    logic             critical;
    logic             end_of_report;
  } res_t;

endpackage
`default_nettype wire

// ===== rtl/cpat_if.sv =====
`default_nettype none
// activity load request channel
interface cpat_in_if import cpat_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [ACT_W-1:0]         edge_index;
  logic [EVT_W-1:0]         from_vertex;
  logic [EVT_W-1:0]         to_vertex;
  logic [DURATION_BITS-1:0] duration;
  logic                     last;

  modport source (output valid, edge_index, from_vertex, to_vertex, duration, last,
                  input ready);
  modport sink (input valid, edge_index, from_vertex, to_vertex, duration, last,
                output ready);
endinterface

// activity report channel
interface cpat_out_if import cpat_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] activity_index;
  time_t            earliest_start;
  time_t            latest_start;
  logic             critical;
  logic             end_of_report;

  modport source (output valid, activity_index, earliest_start, latest_start, critical,
                  end_of_report, input ready);
  modport sink (input valid, activity_index, earliest_start, latest_start, critical,
                end_of_report, output ready);
endinterface
`default_nettype wire

// ===== rtl/cpat_alu.sv =====
`default_nettype none
// Shared relaxation unit: saturating add or floored subtract, then compare
// against the current value (greater for add, less for subtract).
module cpat_alu import cpat_pkg::*; (
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [TIME_W:0] sum;
  time_t           res;

  always_comb begin
    sum = {1'b0, req.a} + {1'b0, req.b};
    if (req.op == ALU_ADD_SAT) begin
      res        = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
      rsp.better = res > req.t;
    end else begin
      res        = (req.a >= req.b) ? (req.a - req.b) : '0;
      rsp.better = res < req.t;
    end
    rsp.c = res;
  end

endmodule
`default_nettype wire

// ===== rtl/cpat_core.sv =====
`default_nettype none
`include "critical_path_activity_times_unit_macros.svh"
// Sequencer, activity table, event time memories and relaxation datapath.
module cpat_core import cpat_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  cpat_in_if.sink in_req,
  output logic    res_valid,
  input  logic    res_ready,
  output res_t    res
);

  localparam logic [2:0] ST_LOAD     = 3'd0;
  localparam logic [2:0] ST_EDGE     = 3'd1;
  localparam logic [2:0] ST_EVT      = 3'd2;
  localparam logic [2:0] ST_EXEC     = 3'd3;
  localparam logic [2:0] ST_SCAN_RD  = 3'd4;
  localparam logic [2:0] ST_SCAN_CMP = 3'd5;

  localparam logic [1:0] PH_FWD = 2'd0;
  localparam logic [1:0] PH_BWD = 2'd1;
  localparam logic [1:0] PH_RPT = 2'd2;

  typedef struct packed {
    logic [EVT_W-1:0]         src;
    logic [EVT_W-1:0]         dst;
    logic [DURATION_BITS-1:0] dur;
  } edge_t;

  // control state
  logic [2:0]            state_r, state_nxt;
  logic [1:0]            phase_r, phase_nxt;
  logic [ACT_W-1:0]      k_r, k_nxt;
  logic [EVT_W-1:0]      pass_r, pass_nxt;
  logic [EVT_W-1:0]      v_r, v_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  time_t                 end_time_r, end_time_nxt;
  logic                  any_sink_r, any_sink_nxt;
  logic [MAX_EVENTS-1:0] pred_r, pred_nxt;
  logic [MAX_EVENTS-1:0] succ_r, succ_nxt;
  logic [MAX_EVENTS-1:0] evld_r, evld_nxt;
  logic [MAX_EVENTS-1:0] lvld_r, lvld_nxt;

  // storage
  edge_t edge_mem [MAX_ACTIVITIES];
  time_t early_mem [MAX_EVENTS];
  time_t late_mem [MAX_EVENTS];

  edge_t      edge_q;
  time_t      early_a_q, early_b_q, late_a_q, late_b_q;
  logic       evld_a_q, evld_b_q, lvld_a_q, lvld_b_q, sink_a_q, sink_b_q;
  logic [EVT_W-1:0] rd_a_addr, rd_b_addr;

  logic     load_acc, k_last, pass_last, v_last, step_done;
  logic     early_we, late_we;
  time_t    e_from, e_to, l_from, l_to, dur_ext, ls;
  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  assign in_req.ready = (state_r == ST_LOAD);
  assign load_acc     = in_req.valid && (state_r == ST_LOAD);

  assign k_last    = (CNT_W'(k_r) + CNT_W'(1)) == count_r;
  assign pass_last = (pass_r == EVT_W'(MAX_EVENTS - 1));
  assign v_last    = (v_r == EVT_W'(MAX_EVENTS - 1));

  // activity table
  always_ff @(posedge clk) begin
    if (load_acc) begin
      edge_mem[in_req.edge_index] <= '{src: in_req.from_vertex, dst: in_req.to_vertex,
                                       dur: in_req.duration};
    end
    if (state_r == ST_EDGE) begin
      edge_q <= edge_mem[k_r];
    end
  end

  // event time reads: port A at the start event (or scan index), port B at the end event
  assign rd_a_addr = (state_r == ST_SCAN_RD) ? v_r : edge_q.src;
  assign rd_b_addr = edge_q.dst;

  always_ff @(posedge clk) begin
    if (early_we) begin
      early_mem[edge_q.dst] <= alu_rsp.c;
    end
    if (late_we) begin
      late_mem[edge_q.src] <= alu_rsp.c;
    end
    early_a_q <= early_mem[rd_a_addr];
    early_b_q <= early_mem[rd_b_addr];
    late_a_q  <= late_mem[rd_a_addr];
    late_b_q  <= late_mem[rd_b_addr];
    evld_a_q  <= evld_r[rd_a_addr];
    evld_b_q  <= evld_r[rd_b_addr];
    lvld_a_q  <= lvld_r[rd_a_addr];
    lvld_b_q  <= lvld_r[rd_b_addr];
    sink_a_q  <= pred_r[rd_a_addr] & ~succ_r[rd_a_addr];
    sink_b_q  <= pred_r[rd_b_addr] & ~succ_r[rd_b_addr];
  end

  // unwritten earliest reads zero, unwritten latest reads unset, sinks read end time
  assign e_from  = evld_a_q ? early_a_q : '0;
  assign e_to    = evld_b_q ? early_b_q : '0;
  assign l_from  = sink_a_q ? end_time_r : (lvld_a_q ? late_a_q : TIME_UNSET);
  assign l_to    = sink_b_q ? end_time_r : (lvld_b_q ? late_b_q : TIME_UNSET);
  assign dur_ext = TIME_W'(edge_q.dur);

  // operand selection for the shared unit
  always_comb begin
    alu_req = '{op: ALU_ADD_SAT, a: e_from, b: dur_ext, t: e_to};
    if (state_r == ST_SCAN_CMP) begin
      alu_req = '{op: ALU_ADD_SAT, a: e_from, b: '0, t: end_time_r};
    end else if (phase_r == PH_BWD) begin
      alu_req = '{op: ALU_SUB_FLOOR, a: l_to, b: dur_ext, t: l_from};
    end else if (phase_r == PH_RPT) begin
      alu_req = '{op: ALU_SUB_FLOOR, a: l_to, b: dur_ext, t: '0};
    end
  end

  cpat_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign early_we = (state_r == ST_EXEC) && (phase_r == PH_FWD) && alu_rsp.better;
  assign late_we  = (state_r == ST_EXEC) && (phase_r == PH_BWD) && alu_rsp.better &&
                    (l_to != TIME_UNSET);

  // report item
  assign ls        = (l_to == TIME_UNSET) ? TIME_MAX : alu_rsp.c;
  assign res_valid = (state_r == ST_EXEC) && (phase_r == PH_RPT);
  assign res       = '{activity_index: k_r, earliest_start: e_from, latest_start: ls,
                       critical: (e_from == ls), end_of_report: k_last};

  assign step_done = (phase_r != PH_RPT) || res_ready;

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    phase_nxt    = phase_r;
    k_nxt        = k_r;
    pass_nxt     = pass_r;
    v_nxt        = v_r;
    count_nxt    = count_r;
    end_time_nxt = end_time_r;
    any_sink_nxt = any_sink_r;
    pred_nxt     = pred_r;
    succ_nxt     = succ_r;
    evld_nxt     = evld_r;
    lvld_nxt     = lvld_r;
    if (early_we) begin
      evld_nxt[edge_q.dst] = 1'b1;
    end
    if (late_we) begin
      lvld_nxt[edge_q.src] = 1'b1;
    end
    case (state_r)
      ST_LOAD: begin
        if (load_acc) begin
          succ_nxt[in_req.from_vertex] = 1'b1;
          pred_nxt[in_req.to_vertex]   = 1'b1;
          if (count_r != CNT_W'(MAX_ACTIVITIES)) begin
            count_nxt = count_r + CNT_W'(1);
          end
          if (in_req.last) begin
            state_nxt = ST_EDGE;
            phase_nxt = PH_FWD;
            k_nxt     = '0;
            pass_nxt  = '0;
          end
        end
      end
      ST_EDGE: state_nxt = ST_EVT;
      ST_EVT:  state_nxt = ST_EXEC;
      ST_EXEC: begin
        if (step_done) begin
          state_nxt = ST_EDGE;
          if (!k_last) begin
            k_nxt = k_r + ACT_W'(1);
          end else begin
            k_nxt = '0;
            if (phase_r == PH_RPT) begin
              // report done: clear for the next network
              state_nxt = ST_LOAD;
              count_nxt = '0;
              pred_nxt  = '0;
              succ_nxt  = '0;
              evld_nxt  = '0;
              lvld_nxt  = '0;
            end else if (!pass_last) begin
              pass_nxt = pass_r + EVT_W'(1);
            end else begin
              pass_nxt = '0;
              if (phase_r == PH_FWD) begin
                state_nxt    = ST_SCAN_RD;
                v_nxt        = '0;
                end_time_nxt = '0;
                any_sink_nxt = 1'b0;
              end else begin
                phase_nxt = PH_RPT;
              end
            end
          end
        end
      end
      ST_SCAN_RD: state_nxt = ST_SCAN_CMP;
      ST_SCAN_CMP: begin
        // project end: largest earliest time over sink events
        if (sink_a_q && (!any_sink_r || alu_rsp.better)) begin
          end_time_nxt = alu_rsp.c;
          any_sink_nxt = 1'b1;
        end
        if (v_last) begin
          state_nxt = ST_EDGE;
          phase_nxt = PH_BWD;
          k_nxt     = '0;
          pass_nxt  = '0;
        end else begin
          state_nxt = ST_SCAN_RD;
          v_nxt     = v_r + EVT_W'(1);
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_LOAD;
      phase_r    <= PH_FWD;
      k_r        <= '0;
      pass_r     <= '0;
      v_r        <= '0;
      count_r    <= '0;
      end_time_r <= '0;
      any_sink_r <= 1'b0;
      pred_r     <= '0;
      succ_r     <= '0;
      evld_r     <= '0;
      lvld_r     <= '0;
    end else begin
      state_r    <= state_nxt;
      phase_r    <= phase_nxt;
      k_r        <= k_nxt;
      pass_r     <= pass_nxt;
      v_r        <= v_nxt;
      count_r    <= count_nxt;
      end_time_r <= end_time_nxt;
      any_sink_r <= any_sink_nxt;
      pred_r     <= pred_nxt;
      succ_r     <= succ_nxt;
      evld_r     <= evld_nxt;
      lvld_r     <= lvld_nxt;
    end
  end

  `ASSERT_ALWAYS(a_count_bound, count_r <= CNT_W'(MAX_ACTIVITIES))
  `ASSERT_ALWAYS(a_rpt_index, !res_valid || (CNT_W'(k_r) < count_r))
  `ASSERT_NEXT(a_run_nonempty, in_req.valid && in_req.ready && in_req.last, count_r != '0 && state_r == ST_EDGE)
  `ASSERT_NEXT(a_clear_after_rpt, res_valid && res_ready && res.end_of_report, count_r == '0 && state_r == ST_LOAD && lvld_r == '0)

endmodule
`default_nettype wire

// ===== rtl/critical_path_activity_times_unit.sv =====
// Loads: one activity request per cycle while idle; the request with last set starts the run.
// Run for N loaded activities: 2 x 64 relaxation passes over the activity table, each activity
// taking a table read, an event memory read and a shared add/compare and write, with a scan over
// all 64 event slots for the sinks between the forward and the backward passes.
// Report: results come one at a time and stall under back-pressure; no load is taken until the last is out.
// Reset (rst_n low, synchronous): sequencer idle, counts, event flags and time marks cleared.
`default_nettype none
`include "critical_path_activity_times_unit_macros.svh"
module critical_path_activity_times_unit import cpat_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  cpat_in_if.sink    in_req,
  cpat_out_if.source out_res
);

  logic res_valid, res_ready;
  res_t res;
  logic out_valid_r;
  res_t out_data_r;

  cpat_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register: takes a new result when empty or being drained
  assign res_ready = !out_valid_r || out_res.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res;
    end
  end

  assign out_res.valid          = out_valid_r;
  assign out_res.activity_index = out_data_r.activity_index;
  assign out_res.earliest_start = out_data_r.earliest_start;
  assign out_res.latest_start   = out_data_r.latest_start;
  assign out_res.critical       = out_data_r.critical;
  assign out_res.end_of_report  = out_data_r.end_of_report;

  `ASSERT_NEXT(a_res_taken, res_valid && res_ready, out_valid_r)

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import cpat_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_LOADS = 112;
  localparam int LONG_HOLD    = 2000;
  localparam int DRAIN_CYCLES = 200;
  localparam int MAX_SHOWN    = 10;
  localparam int DIRECTED_N   = 18;
  localparam int TYPED_N      = 3;

  // one activity load request as the sender sees it
  typedef struct packed {
    logic [ACT_W-1:0]         act;
    logic [EVT_W-1:0]         src;
    logic [EVT_W-1:0]         dst;
    logic [DURATION_BITS-1:0] dur;
    logic                     last;
    logic                     typed;  // take this network's report from typed_times
  } load_row_t;

  logic clk;
  logic rst_n;

  cpat_in_if  load_ch ();
  cpat_out_if report_ch ();

  critical_path_activity_times_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (load_ch.sink),
    .out_res(report_ch.source)
  );

  // network mirror used to forecast the activity report
  logic [EVT_W-1:0]         plan_src [MAX_ACTIVITIES];
  logic [EVT_W-1:0]         plan_dst [MAX_ACTIVITIES];
  logic [DURATION_BITS-1:0] plan_dur [MAX_ACTIVITIES];
  time_t                    evt_early[MAX_EVENTS];
  time_t                    evt_late [MAX_EVENTS];
  bit                       evt_in   [MAX_EVENTS];
  bit                       evt_out  [MAX_EVENTS];
  int unsigned              plan_count;

  res_t      due_times[$];
  res_t      typed_times[TYPED_N];
  int        typed_pos;
  load_row_t directed_loads[DIRECTED_N];
  load_row_t net_loads[$];

  int cycle_count;
  int error_count;
  int reports_seen;
  int loads_sent;
  int networks_sent;
  int largest_net;
  bit held_long;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // watchdog
  initial begin
    cycle_count = 0;
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d reports still due", cycle_count, due_times.size());
    $display("DONE: errors detected");
    $finish;
  end

  function automatic time_t add_sat(time_t a, logic [DURATION_BITS-1:0] d);
    logic [TIME_W:0] s;
    s = {1'b0, a} + (TIME_W + 1)'(d);
    return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
  endfunction

  function automatic time_t sub_floor(time_t a, logic [DURATION_BITS-1:0] d);
    time_t dx;
    dx = TIME_W'(d);
    return (a >= dx) ? a - dx : '0;
  endfunction

  task automatic clear_plan();
    for (int v = 0; v < MAX_EVENTS; v++) begin
      evt_early[v] = '0;
      evt_late[v]  = TIME_UNSET;
      evt_in[v]    = 1'b0;
      evt_out[v]   = 1'b0;
    end
    for (int k = 0; k < MAX_ACTIVITIES; k++) begin
      plan_src[k] = '0;
      plan_dst[k] = '0;
      plan_dur[k] = '0;
    end
    plan_count = 0;
  endtask

  // Record one accepted load; on the last one, run both relaxations and queue the report.
  task automatic apply_load(input load_row_t r);
    time_t c;
    time_t lt;
    time_t es;
    time_t ls;
    time_t end_time;
    bit    any_sink;
    res_t  rpt;
    plan_src[r.act] = r.src;
    plan_dst[r.act] = r.dst;
    plan_dur[r.act] = r.dur;
    evt_out[r.src]  = 1'b1;
    evt_in[r.dst]   = 1'b1;
    if (plan_count < MAX_ACTIVITIES) plan_count++;
    if (!r.last) return;

    // forward: earliest event times, fixed pass count
    for (int p = 0; p < MAX_EVENTS; p++) begin
      for (int k = 0; k < plan_count; k++) begin
        c = add_sat(evt_early[plan_src[k]], plan_dur[k]);
        if (c > evt_early[plan_dst[k]]) evt_early[plan_dst[k]] = c;
      end
    end

    // project end over the sinks
    end_time = '0;
    any_sink = 1'b0;
    for (int v = 0; v < MAX_EVENTS; v++) begin
      if (evt_in[v] && !evt_out[v]) begin
        if (!any_sink || evt_early[v] > end_time) end_time = evt_early[v];
        any_sink = 1'b1;
      end
    end
    for (int v = 0; v < MAX_EVENTS; v++) begin
      if (evt_in[v] && !evt_out[v]) evt_late[v] = end_time;
    end

    // backward: latest event times
    for (int p = 0; p < MAX_EVENTS; p++) begin
      for (int k = 0; k < plan_count; k++) begin
        lt = evt_late[plan_dst[k]];
        if (lt != TIME_UNSET) begin
          c = sub_floor(lt, plan_dur[k]);
          if (c < evt_late[plan_src[k]]) evt_late[plan_src[k]] = c;
        end
      end
    end

    for (int k = 0; k < plan_count; k++) begin
      es = evt_early[plan_src[k]];
      lt = evt_late[plan_dst[k]];
      ls = (lt == TIME_UNSET) ? TIME_MAX : sub_floor(lt, plan_dur[k]);
      rpt.activity_index = ACT_W'(k);
      rpt.earliest_start = es;
      rpt.latest_start   = ls;
      rpt.critical       = (es == ls);
      rpt.end_of_report  = (k + 1 == plan_count);
      if (r.typed) begin
        rpt = typed_times[typed_pos];
        typed_pos++;
      end
      due_times.push_back(rpt);
    end
    clear_plan();
  endtask

  // mostly short gaps, now and then a long one
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [DURATION_BITS-1:0] pick_duration();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return DURATION_BITS'($urandom_range(1, 20));
      default: return DURATION_BITS'($urandom);
    endcase
  endfunction

  // Random network into net_loads. Untangled ones only go forward along a
  // scrambled event order, so they stay acyclic; tangled ones may loop.
  task automatic build_network(input int n, input bit tangled);
    int slots;
    int pool;
    int base;
    int stride;
    int a;
    int b;
    int j;
    int tmp;
    int order[MAX_ACTIVITIES];
    load_row_t r;
    net_loads.delete();
    slots = (n < MAX_ACTIVITIES) ? n : MAX_ACTIVITIES;
    pool  = slots + 1 + $urandom_range(0, 2);
    if (pool > MAX_EVENTS) pool = MAX_EVENTS;
    base   = $urandom_range(0, MAX_EVENTS - 1);
    stride = 2 * $urandom_range(0, MAX_EVENTS / 2 - 1) + 1;
    for (int i = 0; i < slots; i++) order[i] = i;
    for (int i = slots - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int k = 0; k < n; k++) begin
      if (tangled) begin
        a = $urandom_range(0, pool - 1);
        b = $urandom_range(0, pool - 1);
      end else begin
        a = $urandom_range(0, pool - 2);
        b = $urandom_range(0, 1) ? a + 1 : $urandom_range(a + 1, pool - 1);
      end
      // past the table size a load overwrites some earlier slot
      r.act   = ACT_W'((k < slots) ? order[k] : $urandom_range(0, MAX_ACTIVITIES - 1));
      r.src   = EVT_W'((base + a * stride) % MAX_EVENTS);
      r.dst   = EVT_W'((base + b * stride) % MAX_EVENTS);
      r.dur   = pick_duration();
      r.last  = (k == n - 1);
      r.typed = 1'b0;
      net_loads.push_back(r);
    end
  endtask

  // Offer one load request, hold it until taken, then forecast.
  task automatic offer_load(input load_row_t r, input int gap);
    if (gap > 0) begin
      load_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    load_ch.valid       <= 1'b1;
    load_ch.edge_index  <= r.act;
    load_ch.from_vertex <= r.src;
    load_ch.to_vertex   <= r.dst;
    load_ch.duration    <= r.dur;
    load_ch.last        <= r.last;
    @(posedge clk);
    while (!load_ch.ready) @(posedge clk);
    apply_load(r);
    loads_sent++;
  endtask

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= MAX_SHOWN) $display("ERROR @%0d: %s", cycle_count, msg);
  endtask

  // report checker
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst_n && report_ch.valid && report_ch.ready) begin
      got.activity_index = report_ch.activity_index;
      got.earliest_start = report_ch.earliest_start;
      got.latest_start   = report_ch.latest_start;
      got.critical       = report_ch.critical;
      got.end_of_report  = report_ch.end_of_report;
      reports_seen++;
      if (due_times.size() == 0) begin
        flag_error($sformatf("unexpected report act=%0d es=%0d ls=%0d crit=%0d eor=%0d",
                             got.activity_index, got.earliest_start, got.latest_start,
                             got.critical, got.end_of_report));
      end else begin
        want = due_times.pop_front();
        if (got.activity_index !== want.activity_index ||
            got.earliest_start !== want.earliest_start ||
            got.latest_start   !== want.latest_start ||
            got.critical       !== want.critical ||
            got.end_of_report  !== want.end_of_report) begin
          flag_error($sformatf({"report mismatch exp act=%0d es=%0d ls=%0d crit=%0d eor=%0d",
                                " got act=%0d es=%0d ls=%0d crit=%0d eor=%0d"},
                               want.activity_index, want.earliest_start, want.latest_start,
                               want.critical, want.end_of_report,
                               got.activity_index, got.earliest_start, got.latest_start,
                               got.critical, got.end_of_report));
        end
      end
    end
  end

  // report receiver: random stalls, quiet stretches, one long hold mid-report
  initial begin
    int hold_left;
    int calm_left;
    hold_left = 0;
    calm_left = 0;
    held_long = 1'b0;
    report_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        report_ch.ready <= 1'b0;
      end else begin
        report_ch.ready <= 1'b1;
        if (!held_long && report_ch.valid && reports_seen >= 24) begin
          held_long = 1'b1;
          hold_left = LONG_HOLD;
        end else if (calm_left > 0) begin
          calm_left--;
        end else if ($urandom_range(0, 39) == 0) begin
          calm_left = $urandom_range(20, 200);
        end else if ($urandom_range(0, 2) == 0) begin
          hold_left = idle_cycles();
        end
      end
    end
  end

  // stimulus
  initial begin
    int  n;
    bit  tangled;
    bit  calm;
    bit  big_done;
    int  random_loads;
    error_count   = 0;
    reports_seen  = 0;
    loads_sent    = 0;
    networks_sent = 0;
    largest_net   = 0;
    typed_pos     = 0;
    big_done      = 1'b0;
    random_loads  = 0;
    clear_plan();

    // act, src, dst, dur, last, typed
    directed_loads = '{
      // single activity across the widest event span, longest duration
      '{6'd0, 6'd0, 6'd63, 16'hFFFF, 1'b1, 1'b1},
      // two-event loop with no sink: times saturate, latest never set
      '{6'd0, 6'd5, 6'd6, 16'hFFFF, 1'b0, 1'b0},
      '{6'd1, 6'd6, 6'd5, 16'hFFFF, 1'b1, 1'b1},
      // diamond loaded out of index order, two sinks, a zero duration
      '{6'd2, 6'd10, 6'd12, 16'd5,   1'b0, 1'b0},
      '{6'd0, 6'd10, 6'd11, 16'd100, 1'b0, 1'b0},
      '{6'd3, 6'd12, 6'd13, 16'd0,   1'b0, 1'b0},
      '{6'd1, 6'd11, 6'd13, 16'd7,   1'b0, 1'b0},
      '{6'd4, 6'd10, 6'd14, 16'd3,   1'b1, 1'b0},
      // all-zero chain through the top event numbers
      '{6'd0, 6'd63, 6'd62, 16'd0, 1'b0, 1'b0},
      '{6'd1, 6'd62, 6'd0,  16'd0, 1'b1, 1'b0},
      // loop feeding a sink: latest times in the loop floor at zero
      '{6'd0, 6'd20, 6'd21, 16'd1,     1'b0, 1'b0},
      '{6'd1, 6'd21, 6'd20, 16'd1,     1'b0, 1'b0},
      '{6'd2, 6'd21, 6'd22, 16'd40000, 1'b1, 1'b0},
      // self loop
      '{6'd0, 6'd33, 6'd33, 16'd9, 1'b1, 1'b0},
      // parallel activities, two sources, slack on the short branches
      '{6'd0, 6'd1, 6'd2, 16'd30,    1'b0, 1'b0},
      '{6'd1, 6'd1, 6'd2, 16'd50,    1'b0, 1'b0},
      '{6'd2, 6'd3, 6'd2, 16'd10,    1'b0, 1'b0},
      '{6'd3, 6'd2, 6'd4, 16'hFFFF,  1'b1, 1'b0}
    };
    // act, earliest, latest, critical, end_of_report
    typed_times = '{
      '{6'd0, 22'd0, 22'd0, 1'b1, 1'b1},
      '{6'd0, TIME_MAX, TIME_MAX, 1'b1, 1'b0},
      '{6'd1, TIME_MAX, TIME_MAX, 1'b1, 1'b1}
    };

    rst_n <= 1'b0;
    load_ch.valid       <= 1'b0;
    load_ch.edge_index  <= '0;
    load_ch.from_vertex <= '0;
    load_ch.to_vertex   <= '0;
    load_ch.duration    <= '0;
    load_ch.last        <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed networks
    foreach (directed_loads[i]) begin
      offer_load(directed_loads[i], idle_cycles());
      if (directed_loads[i].last) networks_sent++;
    end
    largest_net = 5;

    // let the block drain completely before the random part
    load_ch.valid <= 1'b0;
    while (due_times.size() != 0) @(posedge clk);
    @(posedge clk);

    // random networks, one of them past the full table size
    while (random_loads < RANDOM_LOADS) begin
      if (!big_done && random_loads >= 30) begin
        n = MAX_ACTIVITIES + 2;
        tangled = 1'b0;
        big_done = 1'b1;
      end else begin
        n = $urandom_range(1, 8);
        tangled = ($urandom_range(0, 4) == 0);
      end
      calm = ($urandom_range(0, 3) == 0);
      build_network(n, tangled);
      foreach (net_loads[k]) offer_load(net_loads[k], calm ? 0 : idle_cycles());
      random_loads += n;
      networks_sent++;
      if (n > largest_net) largest_net = n;
    end

    // drain and wrap up
    load_ch.valid <= 1'b0;
    while (due_times.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    error_count += due_times.size();
    $display("covered %0d networks (%0d loads, up to %0d per network, loops and saturation)",
             networks_sent, loads_sent, largest_net);
    $display("checked %0d activity reports in %0d cycles, long receiver hold %0s",
             reports_seen, cycle_count, held_long ? "applied" : "not reached");
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/cpat_pkg.sv
rtl/cpat_if.sv
rtl/cpat_alu.sv
rtl/cpat_core.sv
rtl/critical_path_activity_times_unit.sv
tb/sv/testbench.sv
